### rtl/ufpc_pkg.sv
package ufpc_pkg;

  // Size of the parent store and the field widths that follow from it
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);
  localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_NODES);

  // Request codes
  localparam logic ACT_FIND  = 1'b0;
  localparam logic ACT_MERGE = 1'b1;

  // One write port and one read address into the parent store
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

  // Start of a root search
  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node;
  } walk_req_t;

  // Result of a root search
  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] root;
  } walk_rsp_t;

endpackage

### rtl/ufpc_parent_ram.sv
module ufpc_parent_ram (
  input  logic                           clk,
  input  ufpc_pkg::ram_req_t             req,
  output logic [ufpc_pkg::NODE_W-1:0]    rdata
);

  logic [ufpc_pkg::NODE_W-1:0] mem [ufpc_pkg::MAX_NODES];
  logic [ufpc_pkg::NODE_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ufpc_walker.sv
module ufpc_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ufpc_pkg::walk_req_t            wreq,
  output ufpc_pkg::walk_rsp_t            wrsp,
  output ufpc_pkg::ram_req_t             ram_req,
  input  logic [ufpc_pkg::NODE_W-1:0]    ram_rdata
);

  typedef enum logic [1:0] {
    W_IDLE,
    W_WALK,
    W_COMP
  } wstate_t;

  wstate_t state_r, state_nxt;
  logic [ufpc_pkg::NODE_W-1:0] cur_r, cur_nxt;
  logic [ufpc_pkg::NODE_W-1:0] node_r, node_nxt;
  logic [ufpc_pkg::NODE_W-1:0] root_r, root_nxt;
  logic                        done_r, done_nxt;

  // Walk up to the root one link a cycle, then rewrite the path
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    node_nxt      = node_r;
    root_nxt      = root_r;
    done_nxt      = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = cur_r;
    ram_req.wdata = root_r;
    ram_req.raddr = wreq.node;
    case (state_r)
      W_IDLE: begin
        if (wreq.start) begin
          cur_nxt   = wreq.node;
          node_nxt  = wreq.node;
          state_nxt = W_WALK;
        end
      end
      W_WALK: begin
        if (ram_rdata == cur_r) begin
          root_nxt = cur_r;
          if (node_r == cur_r) begin
            done_nxt  = 1'b1;
            state_nxt = W_IDLE;
          end else begin
            // start again from the first node, compressing as we go
            ram_req.raddr = node_r;
            cur_nxt       = node_r;
            state_nxt     = W_COMP;
          end
        end else begin
          ram_req.raddr = ram_rdata;
          cur_nxt       = ram_rdata;
        end
      end
      W_COMP: begin
        ram_req.we = 1'b1;
        if (ram_rdata == root_r) begin
          done_nxt  = 1'b1;
          state_nxt = W_IDLE;
        end else begin
          ram_req.raddr = ram_rdata;
          cur_nxt       = ram_rdata;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cur_r  <= cur_nxt;
    node_r <= node_nxt;
    root_r <= root_nxt;
  end

  assign wrsp.done = done_r;
  assign wrsp.root = root_r;

endmodule

### rtl/union_find_path_compression_unit.sv
// Disjoint-set engine over a 1024-entry parent store.
// Input channel (in_valid/in_stall): in_action selects find (root of
// in_first_node) or merge (link the set of in_first_node under that of
// in_second_node). A request is taken when in_valid is high and in_stall
// low; in_stall stays high from then until the result has been loaded
// into the output register, so one request is worked on at a time.
// Result channel (out_valid/out_stall): root, joined, component_count and
// bad_index. The result register holds while out_stall is high; a new
// request may be taken while a result waits there, and a finished one
// waits for the register to empty.
// From acceptance to out_valid, a find follows each link from the node to
// its root, sees the root, rewrites each link on the path to point at the
// root, hands the root back and loads the result; a merge does this for
// both nodes and then links the roots. A bad index skips the search.
// The next request can be taken once a result is loaded and the sequencer
// is idle again. The parent store has one read port and one write port.
// Reset and every write of cfg_wr_data start a clearing pass over the whole
// store that makes each node its own parent; in_stall is high meanwhile.
module union_find_path_compression_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ufpc_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [ufpc_pkg::NODE_W-1:0]    in_first_node,
  input  logic [ufpc_pkg::NODE_W-1:0]    in_second_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ufpc_pkg::NODE_W-1:0]    out_root,
  output logic                           out_joined,
  output logic [ufpc_pkg::CNT_W-1:0]     out_component_count,
  output logic                           out_bad_index
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_A,
    S_FIND_B,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [ufpc_pkg::NODE_W-1:0] clr_r, clr_nxt;
  logic [ufpc_pkg::CNT_W-1:0]  nodes_r, nodes_nxt;
  logic [ufpc_pkg::CNT_W-1:0]  sets_r, sets_nxt;
  logic                        action_r, action_nxt;
  logic [ufpc_pkg::NODE_W-1:0] b_r, b_nxt;
  logic [ufpc_pkg::NODE_W-1:0] ra_r, ra_nxt;
  logic [ufpc_pkg::NODE_W-1:0] res_root_r, res_root_nxt;
  logic                        res_joined_r, res_joined_nxt;
  logic                        res_bad_r, res_bad_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ufpc_pkg::NODE_W-1:0] out_root_r, out_root_nxt;
  logic                        out_joined_r, out_joined_nxt;
  logic [ufpc_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;
  logic                        out_bad_r, out_bad_nxt;

  ufpc_pkg::walk_req_t          wreq;
  ufpc_pkg::walk_rsp_t          wrsp;
  ufpc_pkg::ram_req_t           walk_ram;
  ufpc_pkg::ram_req_t           ram_req;
  logic [ufpc_pkg::NODE_W-1:0]  ram_rdata;
  logic                         in_take;
  logic                         in_bad;
  logic [ufpc_pkg::CNT_W-1:0]   cfg_clamped;
  logic                         link_we;

  assign in_take = in_valid && !in_stall;
  assign in_bad  = ({1'b0, in_first_node} >= nodes_r) ||
                   ((in_action == ufpc_pkg::ACT_MERGE) && ({1'b0, in_second_node} >= nodes_r));

  // Node count written as zero counts as one, above the store size as full
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_clamped = ufpc_pkg::CNT_W'(1);
    end else if (cfg_wr_data > ufpc_pkg::MAX_COUNT) begin
      cfg_clamped = ufpc_pkg::MAX_COUNT;
    end else begin
      cfg_clamped = cfg_wr_data;
    end
  end

  // Request sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    nodes_nxt      = nodes_r;
    sets_nxt       = sets_r;
    action_nxt     = action_r;
    b_nxt          = b_r;
    ra_nxt         = ra_r;
    res_root_nxt   = res_root_r;
    res_joined_nxt = res_joined_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_root_nxt   = out_root_r;
    out_joined_nxt = out_joined_r;
    out_count_nxt  = out_count_r;
    out_bad_nxt    = out_bad_r;
    wreq.start     = 1'b0;
    wreq.node      = in_first_node;
    link_we        = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ufpc_pkg::LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          action_nxt     = in_action;
          b_nxt          = in_second_node;
          res_joined_nxt = 1'b0;
          if (in_bad) begin
            res_root_nxt = '0;
            res_bad_nxt  = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            res_bad_nxt = 1'b0;
            wreq.start  = 1'b1;
            state_nxt   = S_FIND_A;
          end
        end
      end
      S_FIND_A: begin
        if (wrsp.done) begin
          ra_nxt = wrsp.root;
          if (action_r == ufpc_pkg::ACT_FIND) begin
            res_root_nxt = wrsp.root;
            state_nxt    = S_OUT;
          end else begin
            wreq.start = 1'b1;
            wreq.node  = b_r;
            state_nxt  = S_FIND_B;
          end
        end
      end
      S_FIND_B: begin
        if (wrsp.done) begin
          res_root_nxt = wrsp.root;
          if (ra_r != wrsp.root) begin
            // link first root under second
            link_we        = 1'b1;
            res_joined_nxt = 1'b1;
            if (sets_r != '0) begin
              sets_nxt = sets_r - 1'b1;
            end
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = res_root_r;
          out_joined_nxt = res_joined_r;
          out_count_nxt  = sets_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
    // A node count write restarts the store
    if (cfg_wr_en) begin
      nodes_nxt = cfg_clamped;
      sets_nxt  = cfg_clamped;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nodes_r     <= ufpc_pkg::MAX_COUNT;
      sets_r      <= ufpc_pkg::MAX_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nodes_r     <= nodes_nxt;
      sets_r      <= sets_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r     <= action_nxt;
    b_r          <= b_nxt;
    ra_r         <= ra_nxt;
    res_root_r   <= res_root_nxt;
    res_joined_r <= res_joined_nxt;
    res_bad_r    <= res_bad_nxt;
    out_root_r   <= out_root_nxt;
    out_joined_r <= out_joined_nxt;
    out_count_r  <= out_count_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // Store port: clearing pass, root link, or the walker
  always_comb begin
    ram_req = walk_ram;
    if (state_r == S_CLEAR) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_r;
      ram_req.wdata = clr_r;
    end else if (link_we) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = ra_r;
      ram_req.wdata = wrsp.root;
    end
  end

  ufpc_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .wreq      (wreq),
    .wrsp      (wrsp),
    .ram_req   (walk_ram),
    .ram_rdata (ram_rdata)
  );

  ufpc_parent_ram u_parent_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_root            = out_root_r;
  assign out_joined          = out_joined_r;
  assign out_component_count = out_count_r;
  assign out_bad_index       = out_bad_r;

endmodule

### sim/union_find_path_compression_unit_tb.sv
`timescale 1ns / 100ps

module union_find_path_compression_unit_tb;

  localparam int HALF_PERIOD  = 4;
  localparam int SETTLE_CYCLES = 8;

  // One answer of the engine, field by field
  typedef struct packed {
    logic [ufpc_pkg::NODE_W-1:0] root;
    logic                        joined;
    logic [ufpc_pkg::CNT_W-1:0]  count;
    logic                        bad;
  } set_answer_t;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        cfg_wr_en      = 1'b0;
  logic [ufpc_pkg::CNT_W-1:0]  cfg_wr_data    = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_action      = ufpc_pkg::ACT_FIND;
  logic [ufpc_pkg::NODE_W-1:0] in_first_node  = '0;
  logic [ufpc_pkg::NODE_W-1:0] in_second_node = '0;
  logic                        out_stall      = 1'b0;
  wire                         in_stall;
  wire                         out_valid;
  wire [ufpc_pkg::NODE_W-1:0]  out_root;
  wire                         out_joined;
  wire [ufpc_pkg::CNT_W-1:0]   out_component_count;
  wire                         out_bad_index;

  // Shadow of the engine state
  logic [ufpc_pkg::NODE_W-1:0] parent_links [ufpc_pkg::MAX_NODES];
  int                          live_sets;
  int                          nodes_in_use;
  set_answer_t                 answer_queue [$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  union_find_path_compression_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_first_node       (in_first_node),
    .in_second_node      (in_second_node),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_root            (out_root),
    .out_joined          (out_joined),
    .out_component_count (out_component_count),
    .out_bad_index       (out_bad_index)
  );

  always #HALF_PERIOD clk = ~clk;

  // Clear every set; zero counts as one, anything past the store as full
  function automatic void clear_sets(input logic [ufpc_pkg::CNT_W-1:0] value);
    if (value == '0) begin
      nodes_in_use = 1;
    end else if (value > ufpc_pkg::MAX_NODES) begin
      nodes_in_use = ufpc_pkg::MAX_NODES;
    end else begin
      nodes_in_use = int'(value);
    end
    for (int i = 0; i < ufpc_pkg::MAX_NODES; i++) begin
      parent_links[i] = ufpc_pkg::NODE_W'(i);
    end
    live_sets = nodes_in_use;
  endfunction

  // Follow links to the root, then point the whole path at it
  function automatic logic [ufpc_pkg::NODE_W-1:0] find_and_flatten(
      input logic [ufpc_pkg::NODE_W-1:0] node);
    logic [ufpc_pkg::NODE_W-1:0] cur;
    logic [ufpc_pkg::NODE_W-1:0] top;
    logic [ufpc_pkg::NODE_W-1:0] nxt;
    int                          steps;
    cur   = node;
    steps = 0;
    while (steps < ufpc_pkg::MAX_NODES && parent_links[cur] != cur) begin
      cur = parent_links[cur];
      steps++;
    end
    top   = cur;
    cur   = node;
    steps = 0;
    while (steps < ufpc_pkg::MAX_NODES && cur != top) begin
      nxt               = parent_links[cur];
      parent_links[cur] = top;
      cur               = nxt;
      steps++;
    end
    return top;
  endfunction

  // Apply one request to the shadow state and give its answer
  function automatic set_answer_t resolve_request(input logic act,
                                                  input logic [ufpc_pkg::NODE_W-1:0] a,
                                                  input logic [ufpc_pkg::NODE_W-1:0] b);
    set_answer_t                 ans;
    logic [ufpc_pkg::NODE_W-1:0] ra;
    logic [ufpc_pkg::NODE_W-1:0] rb;
    ans = '0;
    if (a >= nodes_in_use || (act == ufpc_pkg::ACT_MERGE && b >= nodes_in_use)) begin
      ans.bad = 1'b1;
    end else if (act == ufpc_pkg::ACT_FIND) begin
      ans.root = find_and_flatten(a);
    end else begin
      ra = find_and_flatten(a);
      rb = find_and_flatten(b);
      if (ra != rb) begin
        parent_links[ra] = rb;
        if (live_sets > 0) live_sets--;
        ans.joined = 1'b1;
      end
      ans.root = rb;
    end
    ans.count = ufpc_pkg::CNT_W'(live_sets);
    return ans;
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted answer with the oldest one owed
  always @(posedge clk) begin : check_answers
    set_answer_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (answer_queue.size() == 0) begin
        $error("answer with no request outstanding: root %0d", out_root);
        fail_count++;
      end else begin
        want = answer_queue.pop_front();
        if (out_root !== want.root) begin
          $error("root: expected %0d, got %0d", want.root, out_root);
          fail_count++;
        end
        if (out_joined !== want.joined) begin
          $error("joined: expected %0d, got %0d", want.joined, out_joined);
          fail_count++;
        end
        if (out_component_count !== want.count) begin
          $error("component_count: expected %0d, got %0d", want.count,
                 out_component_count);
          fail_count++;
        end
        if (out_bad_index !== want.bad) begin
          $error("bad_index: expected %0d, got %0d", want.bad, out_bad_index);
          fail_count++;
        end
      end
    end
  end

  // Present one request, with a random gap first, and wait for it to be taken
  task automatic send_request(input logic act, input logic [ufpc_pkg::NODE_W-1:0] a,
                              input logic [ufpc_pkg::NODE_W-1:0] b);
    set_answer_t owed;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_action      = act;
    in_first_node  = a;
    in_second_node = b;
    do @(posedge clk); while (in_stall !== 1'b0);
    owed         = resolve_request(act, a, b);
    answer_queue = {answer_queue, owed};
  endtask

  // Stop sending and wait until every answer is in
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (answer_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [ufpc_pkg::CNT_W-1:0] value);
    wait_until_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    clear_sets(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Full store after reset: corner indices, merge within a set, self-merge
  task automatic test_find_merge_edges();
    send_request(ufpc_pkg::ACT_FIND, 10'd0, 10'd0);
    send_request(ufpc_pkg::ACT_FIND, 10'd1023, 10'd1023);
    send_request(ufpc_pkg::ACT_MERGE, 10'd0, 10'd1023);
    send_request(ufpc_pkg::ACT_MERGE, 10'd1023, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd512, 10'd512);
    send_request(ufpc_pkg::ACT_FIND, 10'd0, 10'd1023);
  endtask

  // Node count of zero, above the store, and the bad-index path
  task automatic test_node_count_limits();
    write_node_count(11'd0);
    send_request(ufpc_pkg::ACT_FIND, 10'd0, 10'd1023);
    send_request(ufpc_pkg::ACT_FIND, 10'd1, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd0, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd0, 10'd1);
    send_request(ufpc_pkg::ACT_MERGE, 10'd1, 10'd0);
    send_request(ufpc_pkg::ACT_FIND, 10'd1023, 10'd0);
    write_node_count(11'd2047);
    send_request(ufpc_pkg::ACT_FIND, 10'd1023, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd1023, 10'd1022);
    write_node_count(11'd1025);
    send_request(ufpc_pkg::ACT_FIND, 10'd1023, 10'd1023);
  endtask

  // Build a chain 0 -> 1 -> ... -> 7, then flatten it
  task automatic test_long_chain();
    write_node_count(11'd8);
    for (int i = 0; i < 7; i++) begin
      send_request(ufpc_pkg::ACT_MERGE, ufpc_pkg::NODE_W'(i), ufpc_pkg::NODE_W'(i + 1));
    end
    send_request(ufpc_pkg::ACT_FIND, 10'd0, 10'd0);
    send_request(ufpc_pkg::ACT_FIND, 10'd0, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd7, 10'd0);
    send_request(ufpc_pkg::ACT_FIND, 10'd8, 10'd0);
    send_request(ufpc_pkg::ACT_MERGE, 10'd3, 10'd8);
  endtask

  // Mostly in-range requests, a few with any index at all
  task automatic run_random_segment(input int cfg_value, input int count);
    logic                        act;
    logic [ufpc_pkg::NODE_W-1:0] a;
    logic [ufpc_pkg::NODE_W-1:0] b;
    write_node_count(ufpc_pkg::CNT_W'(cfg_value));
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(99) < 60) ? ufpc_pkg::ACT_MERGE : ufpc_pkg::ACT_FIND;
      if ($urandom_range(99) < 8) begin
        a = ufpc_pkg::NODE_W'($urandom);
        b = ufpc_pkg::NODE_W'($urandom);
      end else begin
        a = ufpc_pkg::NODE_W'($urandom_range(nodes_in_use - 1));
        b = ufpc_pkg::NODE_W'($urandom_range(nodes_in_use - 1));
      end
      send_request(act, a, b);
    end
  endtask

  // Random traffic under each idling pattern and several node counts
  task automatic test_random_traffic();
    int send_plan [4] = '{0, 51, 0, 9};
    int recv_plan [4] = '{0, 0, 51, 9};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      run_random_segment((p % 2 == 0) ? ufpc_pkg::MAX_NODES : $urandom_range(2047, 1025),
                         105);
      run_random_segment($urandom_range(64, 2), 105);
      run_random_segment($urandom_range(300, 65), 105);
      run_random_segment($urandom_range(16, 1), 105);
    end
  endtask

  // Sender holds off mid-stream until every answer has come back
  task automatic test_pause_until_drained();
    logic [ufpc_pkg::NODE_W-1:0] a;
    logic [ufpc_pkg::NODE_W-1:0] b;
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    write_node_count(11'd40);
    for (int i = 0; i < 40; i++) begin
      if (i == 20) wait_until_drained();
      a = ufpc_pkg::NODE_W'($urandom_range(39));
      b = ufpc_pkg::NODE_W'($urandom_range(39));
      send_request(i[0] ? ufpc_pkg::ACT_MERGE : ufpc_pkg::ACT_FIND, a, b);
    end
  endtask

  initial begin
    clear_sets(ufpc_pkg::CNT_W'(ufpc_pkg::MAX_NODES));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_find_merge_edges();
    test_node_count_limits();
    test_long_chain();
    test_random_traffic();
    test_pause_until_drained();

    wait_until_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #32_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
